FILE: design/aced_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aced_pkg: shared types and helpers for the escape decoder
// Result batch type, character constants and UTF-8 / push helpers.
// ----------------------------------------------------------------------------
package aced_pkg;

	localparam int MaxResults = 5;
	localparam int CountW     = $clog2(MaxResults + 1);

	localparam logic [7:0] ChBsl   = 8'h5c;
	localparam logic [7:0] ChLowC  = 8'h63;
	localparam logic [7:0] ChLowX  = 8'h78;
	localparam logic [7:0] ChLowU  = 8'h75;
	localparam logic [7:0] ChUpU   = 8'h55;
	localparam logic [7:0] ChCtlBs = 8'h1c;
	localparam logic [7:0] ChEsc   = 8'h1b;

	localparam logic [7:0] Utf8Lead2 = 8'hC0;
	localparam logic [7:0] Utf8Lead3 = 8'hE0;
	localparam logic [7:0] Utf8Lead4 = 8'hF0;
	localparam logic [7:0] Utf8Cont  = 8'h80;

	typedef struct packed {
		logic [MaxResults-1:0][7:0] b;
		logic [MaxResults-1:0]      vld;
		logic [CountW-1:0]          n;
		logic                       eos;
		logic                       trunc;
	} batch_t;

	function automatic batch_t push(batch_t r, logic [7:0] x);
		batch_t o;
		o = r;
		if (r.n < CountW'(MaxResults)) begin
			o.b[r.n]   = x;
			o.vld[r.n] = 1'b1;
			o.n        = r.n + CountW'(1);
		end
		return o;
	endfunction

	function automatic batch_t put_utf8(batch_t r, logic [31:0] cp);
		batch_t o;
		o = r;
		if (cp < 32'h80) begin
			o = push(o, cp[7:0]);
		end else if (cp < 32'h800) begin
			o = push(o, Utf8Lead2 | {3'b0, cp[10:6]});
			o = push(o, Utf8Cont | {2'b0, cp[5:0]});
		end else if (cp < 32'h10000) begin
			o = push(o, Utf8Lead3 | {4'b0, cp[15:12]});
			o = push(o, Utf8Cont | {2'b0, cp[11:6]});
			o = push(o, Utf8Cont | {2'b0, cp[5:0]});
		end else begin
			o = push(o, Utf8Lead4 | cp[25:18]);
			o = push(o, Utf8Cont | {2'b0, cp[17:12]});
			o = push(o, Utf8Cont | {2'b0, cp[11:6]});
			o = push(o, Utf8Cont | {2'b0, cp[5:0]});
		end
		return o;
	endfunction

endpackage
`default_nettype wire

FILE: design/aced_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aced_core: escape state and single-pass byte decode
// Holds the escape state and turns one input byte into a batch of results.
// ----------------------------------------------------------------------------
module aced_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire logic [7:0]       in_char,
	input  wire logic             is_last,
	output aced_pkg::batch_t      batch
);
	import aced_pkg::*;

	localparam logic [2:0] ModePlain = 3'd0;
	localparam logic [2:0] ModeBsl   = 3'd1;
	localparam logic [2:0] ModeHex   = 3'd2;
	localparam logic [2:0] ModeOct   = 3'd3;
	localparam logic [2:0] ModeCtl   = 3'd4;
	localparam logic [2:0] ModeCtlBs = 3'd5;
	localparam logic [2:0] ModeDrop  = 3'd6;

	localparam logic [1:0] KindX  = 2'd0;
	localparam logic [1:0] KindU4 = 2'd1;
	localparam logic [1:0] KindU8 = 2'd2;

	typedef struct packed {
		batch_t     r;
		logic [2:0] m;
	} step_t;

	logic [2:0]  mode_q;
	logic [1:0]  kind_q;
	logic [31:0] val_q;
	logic [3:0]  dcnt_q;

	step_t       s;
	logic [1:0]  k;
	logic [31:0] v;
	logic [3:0]  dc;
	logic        again;
	logic        hv;
	logic [3:0]  h;
	logic        trunc;

	function automatic step_t put_esc(step_t st, logic [7:0] x);
		step_t o;
		o   = st;
		o.m = ModePlain;
		if (x == 8'h00) begin
			o.m = ModeDrop;
		end else begin
			o.r = push(o.r, x);
		end
		return o;
	endfunction

	function automatic logic [3:0] kind_max(logic [1:0] kk);
		logic [3:0] mx;
		case (kk)
			KindX:   mx = 4'd2;
			KindU4:  mx = 4'd4;
			default: mx = 4'd8;
		endcase
		return mx;
	endfunction

	function automatic step_t finish_hex(step_t st, logic [1:0] kk, logic [31:0] vv,
			logic [3:0] dd);
		step_t o;
		o   = st;
		o.m = ModePlain;
		if (dd == 4'd0) begin
			o.r = push(o.r, ChBsl);
			case (kk)
				KindX:   o.r = push(o.r, ChLowX);
				KindU4:  o.r = push(o.r, ChLowU);
				default: o.r = push(o.r, ChUpU);
			endcase
		end else if (kk == KindX) begin
			o = put_esc(o, vv[7:0]);
		end else begin
			o.r = put_utf8(o.r, vv);
		end
		return o;
	endfunction

	always_comb begin
		hv = 1'b1;
		h  = in_char[3:0];
		if (in_char inside {[8'h30:8'h39]}) begin
			h = in_char[3:0];
		end else if (in_char inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			h = in_char[3:0] + 4'd9;
		end else begin
			hv = 1'b0;
		end
	end

	always_comb begin
		s     = '0;
		s.m   = mode_q;
		k     = kind_q;
		v     = val_q;
		dc    = dcnt_q;
		again = 1'b0;
		trunc = 1'b0;
		case (mode_q)
			ModeBsl: begin
				s.m = ModePlain;
				case (in_char) inside
					8'h61: s.r = push(s.r, 8'h07);
					8'h62: s.r = push(s.r, 8'h08);
					8'h65, 8'h45: s.r = push(s.r, ChEsc);
					8'h66: s.r = push(s.r, 8'h0c);
					8'h6e: s.r = push(s.r, 8'h0a);
					8'h72: s.r = push(s.r, 8'h0d);
					8'h74: s.r = push(s.r, 8'h09);
					8'h76: s.r = push(s.r, 8'h0b);
					ChBsl, 8'h27, 8'h22, 8'h3f: s.r = push(s.r, in_char);
					ChLowX, ChLowU, ChUpU: begin
						s.m = ModeHex;
						k   = (in_char == ChLowX) ? KindX :
						      ((in_char == ChLowU) ? KindU4 : KindU8);
						v   = '0;
						dc  = '0;
					end
					ChLowC: s.m = ModeCtl;
					[8'h30:8'h37]: begin
						s.m = ModeOct;
						v   = {29'b0, in_char[2:0]};
						dc  = 4'd1;
					end
					default: begin
						s.r = push(s.r, ChBsl);
						s.r = push(s.r, in_char);
					end
				endcase
			end
			ModeHex: begin
				if (hv) begin
					v  = {val_q[27:0], h};
					dc = dcnt_q + 4'd1;
					if (dc >= kind_max(kind_q)) begin
						s = finish_hex(s, kind_q, v, dc);
					end
				end else begin
					s     = finish_hex(s, kind_q, val_q, dcnt_q);
					again = (s.m == ModePlain);
				end
			end
			ModeOct: begin
				if ((in_char inside {[8'h30:8'h37]}) && (dcnt_q < 4'd3)) begin
					v  = {val_q[28:0], in_char[2:0]};
					dc = dcnt_q + 4'd1;
					if (dc >= 4'd3) begin
						s = put_esc(s, v[7:0]);
					end
				end else begin
					s     = put_esc(s, val_q[7:0]);
					again = (s.m == ModePlain);
				end
			end
			ModeCtl: begin
				if (in_char == ChBsl) begin
					s.m = ModeCtlBs;
				end else begin
					s = put_esc(s, {3'b0, in_char[4:0]});
				end
			end
			ModeCtlBs: begin
				s     = put_esc(s, ChCtlBs);
				again = (in_char != ChBsl);
			end
			ModeDrop: begin
				s.m = ModeDrop;
			end
			default: begin
				s.m = ModePlain;
				if (in_char == ChBsl) begin
					s.m = ModeBsl;
				end else begin
					s.r = push(s.r, in_char);
				end
			end
		endcase

		if (again) begin
			if (in_char == ChBsl) begin
				s.m = ModeBsl;
			end else begin
				s.r = push(s.r, in_char);
			end
		end

		if (is_last) begin
			case (s.m)
				ModeBsl:   s.r = push(s.r, ChBsl);
				ModeHex:   s = finish_hex(s, k, v, dc);
				ModeOct:   s = put_esc(s, v[7:0]);
				ModeCtl: begin
					s.r = push(s.r, ChBsl);
					s.r = push(s.r, ChLowC);
				end
				ModeCtlBs: s = put_esc(s, ChCtlBs);
				default: ;
			endcase
			trunc = (s.m == ModeDrop);
			if ((trunc || (s.r.n == '0)) && (s.r.n < CountW'(MaxResults))) begin
				s.r.b[s.r.n]   = 8'h00;
				s.r.vld[s.r.n] = 1'b0;
				s.r.n          = s.r.n + CountW'(1);
			end
			s.r.eos   = 1'b1;
			s.r.trunc = trunc;
			s.m       = ModePlain;
			k         = KindX;
			v         = '0;
			dc        = '0;
		end
	end

	assign batch = s.r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModePlain;
			kind_q <= KindX;
			val_q  <= '0;
			dcnt_q <= '0;
		end else if (take) begin
			mode_q <= s.m;
			kind_q <= k;
			val_q  <= v;
			dcnt_q <= dc;
		end
	end

endmodule
`default_nettype wire

FILE: design/aced_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aced_outq: result batch register and serializer
// Holds one decoded batch and hands its results out one transfer at a time.
// ----------------------------------------------------------------------------
module aced_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  take,
	input  wire aced_pkg::batch_t batch,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [7:0]            out_byte,
	output logic                  byte_valid,
	output logic                  end_of_string,
	output logic                  truncated
);
	import aced_pkg::*;

	batch_t            batch_q;
	logic [CountW-1:0] n_q;
	logic [CountW-1:0] rd_q;
	logic              at_tail;
	logic              out_xfer;

	assign out_valid = (rd_q < n_q);
	assign at_tail   = (rd_q == (n_q - CountW'(1)));
	assign out_xfer  = out_valid && !out_stall;
	assign in_stall  = out_valid && !(out_xfer && at_tail);
	assign take      = in_valid && !in_stall;

	assign out_byte      = batch_q.b[rd_q];
	assign byte_valid    = batch_q.vld[rd_q];
	assign end_of_string = batch_q.eos && at_tail;
	assign truncated     = batch_q.trunc && at_tail;

	always_ff @(posedge clk) begin
		if (take) begin
			batch_q <= batch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= '0;
			rd_q <= '0;
		end else if (take) begin
			n_q  <= batch.n;
			rd_q <= '0;
		end else if (out_xfer) begin
			rd_q <= rd_q + CountW'(1);
		end
	end

endmodule
`default_nettype wire

FILE: design/ansi_c_escape_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_c_escape_decoder: $'...' string body decoder
// Decodes escape sequences byte by byte and streams out the decoded bytes.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while in_stall is low and decoded in a
// single pass into a batch of up to five results, which is registered in a
// result register. The batch is handed out one result per transfer; an input
// byte that yields n results (n of 1 or more) occupies the output until its
// last result transfers, and the next byte is taken in the cycle it transfers.
// Bytes that yield no result (a backslash, pending digits, bytes dropped after
// a NUL) do not stall the input. The result register and its read pointer pace this.
module ansi_c_escape_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_char,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             end_of_string,
	output logic             truncated
);
	import aced_pkg::*;

	batch_t batch;
	logic   take;

	aced_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_char (in_char),
		.is_last (is_last),
		.batch   (batch)
	);

	aced_outq u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.take          (take),
		.batch         (batch),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string),
		.truncated     (truncated)
	);

endmodule
`default_nettype wire
